### rtl/battery_charge_control_defines.svh
// Assertion macros used by the battery charge control top level.
`ifndef BATTERY_CHARGE_CONTROL_DEFINES_SVH
`define BATTERY_CHARGE_CONTROL_DEFINES_SVH

// Same-cycle implication, sampled on clk and quiet during reset
`define BCC_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and quiet during reset
`define BCC_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/bcc_pkg.sv
// Types and constants for the battery charge control block.
package bcc_pkg;

	localparam int SAMPLE_W = 10;
	localparam int THRESH_W = 10;
	localparam int CNT_W    = 8;
	localparam int CFG_IDX_W = 2;

	localparam logic [THRESH_W-1:0] THRESH_MAX       = 10'd1000;
	localparam logic [THRESH_W-1:0] START_THRESH_RST = 10'd800;
	localparam logic [THRESH_W-1:0] END_THRESH_RST   = 10'd850;
	localparam logic [THRESH_W-1:0] SWITCH_THRESH_RST = 10'd200;
	localparam logic [THRESH_W-1:0] STOP_THRESH_RST  = 10'd100;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_START_THRESH  = 2'd0,
		REG_END_THRESH    = 2'd1,
		REG_SWITCH_THRESH = 2'd2,
		REG_STOP_THRESH   = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [THRESH_W-1:0] start_th;
		logic [THRESH_W-1:0] end_th;
		logic [THRESH_W-1:0] switch_th;
		logic [THRESH_W-1:0] stop_th;
	} thresh_t;

	// Per-tick side flags carried down the pipeline
	typedef struct packed {
		logic vbat_fail;
		logic prog_fail;
		logic usb_present;
		logic ac_present;
	} tick_flags_t;

	// Shift enables for one window cell
	typedef struct packed {
		logic vbat;
		logic prog;
	} cell_shift_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] avg_vbat;
		logic [SAMPLE_W-1:0] avg_prog;
		logic charging;
		logic charger_enable;
		logic recharge_enable;
		logic start_event;
		logic start_on_ac;
		logic raise_switch_point;
		logic ac_changed;
		logic usb_changed;
		logic charge_state_changed;
		logic next_sample_paused;
	} result_t;

endpackage

### rtl/battery_charge_control.sv
// Top level of the battery charge control block.
`include "battery_charge_control_defines.svh"

// Battery charge control. Each request on s_* is one tick (battery and prog
// samples, supply presence, read-failure flags in s_tuser) and yields exactly
// one result on m_*. Throughput is one tick per clock while m_tready is high;
// the stages are window push and running-sum update, a reciprocal multiply
// that forms both window averages, then the charge sequencer and output
// register. The sample windows are a row of WINDOW cells that shift on each
// push and reset to zero, so no clearing pass follows reset. Each pipeline
// stage moves on as soon as the stage after it is free, so new requests are
// taken while a result waits at the output until the stages fill. Threshold
// writes above 1000 are dropped; write them only while no tick is in flight.
module battery_charge_control import bcc_pkg::*; #(
	parameter int WINDOW       = 10,
	parameter int PULSE_TICKS  = 10,
	parameter int SWITCH_TICKS = 10
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// Tick requests
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// [9:0] vbat_sample, [19:10] prog_sample, [20] usb_present, [21] ac_present
	input  logic [23:0]          s_tdata,
	// [0] vbat_fail, [1] prog_fail
	input  logic [1:0]           s_tuser,
	// Results
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// [9:0] avg_vbat, [19:10] avg_prog, [20] charging, [21] charger_enable,
	// [22] recharge_enable, [23] start_event, [24] start_on_ac,
	// [25] raise_switch_point, [26] ac_changed, [27] usb_changed,
	// [28] charge_state_changed, [29] next_sample_paused
	output logic [31:0]          m_tdata,
	// Threshold writes
	input  logic                 cfg_wen,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [THRESH_W-1:0]  cfg_data
);

	localparam int SUM_W = SAMPLE_W + $clog2(WINDOW);

	thresh_t             thresh_q;
	logic                v1_q, v2_q, v3_q;
	logic                rdy1, rdy2, rdy3, accept;
	cell_shift_t         push;
	logic [SAMPLE_W-1:0] vbat_new, prog_new;
	logic [SAMPLE_W-1:0] vbat_cell [WINDOW];
	logic [SAMPLE_W-1:0] prog_cell [WINDOW];
	logic [SUM_W-1:0]    vbat_sum_q, prog_sum_q, vbat_sum_d, prog_sum_d;
	logic [SUM_W-1:0]    vbat_sum_s1, prog_sum_s1;
	tick_flags_t         flags_in, flags_s1, flags_s2;
	logic [SAMPLE_W-1:0] avg_vbat_s2, avg_prog_s2;
	result_t             res_s3;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q.start_th  <= START_THRESH_RST;
			thresh_q.end_th    <= END_THRESH_RST;
			thresh_q.switch_th <= SWITCH_THRESH_RST;
			thresh_q.stop_th   <= STOP_THRESH_RST;
		end else if (cfg_wen && (cfg_data <= THRESH_MAX)) begin
			case (cfg_reg_t'(cfg_index))
				REG_START_THRESH:  thresh_q.start_th  <= cfg_data;
				REG_END_THRESH:    thresh_q.end_th    <= cfg_data;
				REG_SWITCH_THRESH: thresh_q.switch_th <= cfg_data;
				REG_STOP_THRESH:   thresh_q.stop_th   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Stage handshake: each stage advances when the next one is free
	assign rdy3     = !v3_q || m_tready;
	assign rdy2     = !v2_q || rdy3;
	assign rdy1     = !v1_q || rdy2;
	assign s_tready = rdy1;
	assign accept   = s_tvalid && rdy1;

	assign vbat_new           = s_tdata[9:0];
	assign prog_new           = s_tdata[19:10];
	assign flags_in.vbat_fail   = s_tuser[0];
	assign flags_in.prog_fail   = s_tuser[1];
	assign flags_in.usb_present = s_tdata[20];
	assign flags_in.ac_present  = s_tdata[21];

	// A failed battery read pushes nothing; a failed prog read pushes only vbat
	assign push.vbat = accept && !flags_in.vbat_fail;
	assign push.prog = accept && !flags_in.vbat_fail && !flags_in.prog_fail;

	// Window cells, oldest at index 0
	for (genvar i = 0; i < WINDOW; i++) begin : g_cell
		logic [SAMPLE_W-1:0] vbat_in, prog_in;
		if (i == WINDOW - 1) begin : g_tail
			assign vbat_in = vbat_new;
			assign prog_in = prog_new;
		end else begin : g_link
			assign vbat_in = vbat_cell[i+1];
			assign prog_in = prog_cell[i+1];
		end
		bcc_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.shift   (push),
			.vbat_in (vbat_in),
			.prog_in (prog_in),
			.vbat_q  (vbat_cell[i]),
			.prog_q  (prog_cell[i])
		);
	end

	// Running sums: drop the oldest sample, add the new one
	always_comb begin
		vbat_sum_d = vbat_sum_q;
		prog_sum_d = prog_sum_q;
		if (push.vbat) begin
			vbat_sum_d = vbat_sum_q - SUM_W'(vbat_cell[0]) + SUM_W'(vbat_new);
		end
		if (push.prog) begin
			prog_sum_d = prog_sum_q - SUM_W'(prog_cell[0]) + SUM_W'(prog_new);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vbat_sum_q <= '0;
			prog_sum_q <= '0;
		end else begin
			vbat_sum_q <= vbat_sum_d;
			prog_sum_q <= prog_sum_d;
		end
	end

	// Stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
		end else begin
			if (rdy1) begin
				v1_q <= s_tvalid;
			end
			if (rdy2) begin
				v2_q <= v1_q;
			end
			if (rdy3) begin
				v3_q <= v2_q;
			end
		end
	end

	// Stage 1 payload: sums after this tick
	always_ff @(posedge clk) begin
		if (accept) begin
			vbat_sum_s1 <= vbat_sum_d;
			prog_sum_s1 <= prog_sum_d;
			flags_s1    <= flags_in;
		end
	end

	// Stage 2: averages
	bcc_avg #(
		.WINDOW (WINDOW),
		.SUM_W  (SUM_W)
	) u_avg (
		.clk         (clk),
		.load        (v1_q && rdy2),
		.vbat_sum    (vbat_sum_s1),
		.prog_sum    (prog_sum_s1),
		.avg_vbat_s2 (avg_vbat_s2),
		.avg_prog_s2 (avg_prog_s2)
	);

	always_ff @(posedge clk) begin
		if (v1_q && rdy2) begin
			flags_s2 <= flags_s1;
		end
	end

	// Stage 3: charge sequencer and output register
	bcc_ctrl #(
		.PULSE_TICKS  (PULSE_TICKS),
		.SWITCH_TICKS (SWITCH_TICKS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (v2_q && rdy3),
		.flags    (flags_s2),
		.avg_vbat (avg_vbat_s2),
		.avg_prog (avg_prog_s2),
		.thresh   (thresh_q),
		.res_s3   (res_s3)
	);

	assign m_tvalid = v3_q;
	assign m_tdata  = {2'b00,
		res_s3.next_sample_paused,
		res_s3.charge_state_changed,
		res_s3.usb_changed,
		res_s3.ac_changed,
		res_s3.raise_switch_point,
		res_s3.start_on_ac,
		res_s3.start_event,
		res_s3.recharge_enable,
		res_s3.charger_enable,
		res_s3.charging,
		res_s3.avg_prog,
		res_s3.avg_vbat};

	// A start always leaves the charger on in the same result
	`BCC_ASSERT_NOW(a_start_drives_charger, m_tvalid && m_tdata[23], m_tdata[20] && m_tdata[21], "start without charger on")
	// Full pipeline with a stalled output refuses new requests
	`BCC_ASSERT_NOW(a_full_blocks_input, v1_q && v2_q && v3_q && !m_tready, !s_tready, "request taken while pipeline full")
	// An accepted request always lands in stage 1
	`BCC_ASSERT_NEXT(a_accept_fills_s1, s_tvalid && s_tready, v1_q, "accepted request lost")

endmodule

### rtl/bcc_cell.sv
// One window cell: holds a battery and a prog sample and passes them down the row.
module bcc_cell import bcc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  cell_shift_t         shift,
	input  logic [SAMPLE_W-1:0] vbat_in,
	input  logic [SAMPLE_W-1:0] prog_in,
	output logic [SAMPLE_W-1:0] vbat_q,
	output logic [SAMPLE_W-1:0] prog_q
);

	// Take the neighbor's sample on each push
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vbat_q <= '0;
			prog_q <= '0;
		end else begin
			if (shift.vbat) begin
				vbat_q <= vbat_in;
			end
			if (shift.prog) begin
				prog_q <= prog_in;
			end
		end
	end

endmodule

### rtl/bcc_avg.sv
// Window average stage: divides both running sums by the window depth.
module bcc_avg import bcc_pkg::*; #(
	parameter int WINDOW = 10,
	parameter int SUM_W  = 14
) (
	input  logic                clk,
	input  logic                load,
	input  logic [SUM_W-1:0]    vbat_sum,
	input  logic [SUM_W-1:0]    prog_sum,
	output logic [SAMPLE_W-1:0] avg_vbat_s2,
	output logic [SAMPLE_W-1:0] avg_prog_s2
);

	// Rounded-up reciprocal: exact floor division for every sum below 2^SUM_W
	localparam int SHIFT  = SUM_W + $clog2(WINDOW);
	localparam longint unsigned RECIP_VAL = ((64'd1 << SHIFT) + WINDOW - 1) / WINDOW;
	localparam int RECIP_W = SUM_W + 2;
	localparam int PROD_W  = SUM_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_VAL);

	logic [PROD_W-1:0] vbat_prod;
	logic [PROD_W-1:0] prog_prod;

	assign vbat_prod = PROD_W'(vbat_sum) * PROD_W'(RECIP);
	assign prog_prod = PROD_W'(prog_sum) * PROD_W'(RECIP);

	// Register the quotients
	always_ff @(posedge clk) begin
		if (load) begin
			avg_vbat_s2 <= vbat_prod[SHIFT +: SAMPLE_W];
			avg_prog_s2 <= prog_prod[SHIFT +: SAMPLE_W];
		end
	end

endmodule

### rtl/bcc_ctrl.sv
// Charge sequencer: start, constant-current, pulsed top-off and shutdown decisions.
module bcc_ctrl import bcc_pkg::*; #(
	parameter int PULSE_TICKS  = 10,
	parameter int SWITCH_TICKS = 10
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  tick_flags_t         flags,
	input  logic [SAMPLE_W-1:0] avg_vbat,
	input  logic [SAMPLE_W-1:0] avg_prog,
	input  thresh_t             thresh,
	output result_t             res_s3
);

	localparam logic [CNT_W-1:0] PULSE_INIT  = CNT_W'(PULSE_TICKS);
	localparam logic [CNT_W-1:0] SWITCH_INIT = CNT_W'(SWITCH_TICKS);

	logic             active_q, phase_q, pon_q, chg_q, rech_q, prev_usb_q, prev_ac_q;
	logic [CNT_W-1:0] pulse_cnt_q, switch_cnt_q;

	logic             active_d, phase_d, pon_d, chg_d, rech_d, prev_usb_d, prev_ac_d;
	logic [CNT_W-1:0] pulse_cnt_d, switch_cnt_d;
	logic             start_ev, on_ac, raise, ac_chg, usb_chg, st_chg, supply;
	result_t          res_d;

	// Work out the next charge state for this tick
	always_comb begin
		active_d     = active_q;
		phase_d      = phase_q;
		pon_d        = pon_q;
		chg_d        = chg_q;
		rech_d       = rech_q;
		prev_usb_d   = prev_usb_q;
		prev_ac_d    = prev_ac_q;
		pulse_cnt_d  = pulse_cnt_q;
		switch_cnt_d = switch_cnt_q;
		start_ev     = 1'b0;
		on_ac        = 1'b0;
		raise        = 1'b0;
		ac_chg       = 1'b0;
		usb_chg      = 1'b0;
		st_chg       = 1'b0;
		supply       = flags.usb_present | flags.ac_present;

		if (!flags.vbat_fail && !flags.prog_fail) begin
			ac_chg     = prev_ac_q != flags.ac_present;
			usb_chg    = prev_usb_q != flags.usb_present;
			prev_ac_d  = flags.ac_present;
			prev_usb_d = flags.usb_present;

			// Start a session on a low battery, USB first
			if (supply && (avg_vbat < thresh.start_th) && !active_q) begin
				pulse_cnt_d  = PULSE_INIT;
				switch_cnt_d = SWITCH_INIT;
				active_d     = 1'b1;
				chg_d        = 1'b1;
				rech_d       = 1'b1;
				start_ev     = 1'b1;
				on_ac        = !flags.usb_present;
				st_chg       = 1'b1;
			end

			if (active_d) begin
				if (supply) begin
					if (!phase_d) begin
						// Constant-current phase
						if (avg_vbat < thresh.end_th) begin
							if (switch_cnt_d <= CNT_W'(1)) begin
								raise        = avg_prog < thresh.switch_th;
								switch_cnt_d = SWITCH_INIT;
							end else begin
								switch_cnt_d = switch_cnt_d - CNT_W'(1);
							end
						end else begin
							phase_d = 1'b1;
						end
					end else if (pon_d) begin
						// Pulse on: count down, drop the charger at pulse end
						if (pulse_cnt_d <= CNT_W'(1)) begin
							pon_d  = 1'b0;
							chg_d  = 1'b0;
							rech_d = 1'b0;
							if (avg_prog < thresh.stop_th) begin
								pon_d    = 1'b1;
								phase_d  = 1'b0;
								active_d = 1'b0;
								st_chg   = 1'b1;
							end
							pulse_cnt_d = PULSE_INIT;
						end else begin
							pulse_cnt_d = pulse_cnt_d - CNT_W'(1);
						end
					end else begin
						pon_d  = 1'b1;
						chg_d  = 1'b1;
						rech_d = 1'b1;
					end
				end else begin
					// Supply lost: shut down
					chg_d    = 1'b0;
					rech_d   = 1'b0;
					active_d = 1'b0;
					phase_d  = 1'b0;
					pon_d    = 1'b1;
					st_chg   = 1'b1;
				end
			end
		end

		res_d.avg_vbat             = avg_vbat;
		res_d.avg_prog             = avg_prog;
		res_d.charging             = active_d;
		res_d.charger_enable       = chg_d;
		res_d.recharge_enable      = rech_d;
		res_d.start_event          = start_ev;
		res_d.start_on_ac          = on_ac;
		res_d.raise_switch_point   = raise;
		res_d.ac_changed           = ac_chg;
		res_d.usb_changed          = usb_chg;
		res_d.charge_state_changed = st_chg;
		res_d.next_sample_paused   = phase_d & pon_d;
	end

	// Commit charge state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q     <= 1'b0;
			phase_q      <= 1'b0;
			pon_q        <= 1'b1;
			chg_q        <= 1'b0;
			rech_q       <= 1'b0;
			prev_usb_q   <= 1'b0;
			prev_ac_q    <= 1'b0;
			pulse_cnt_q  <= PULSE_INIT;
			switch_cnt_q <= SWITCH_INIT;
		end else if (load) begin
			active_q     <= active_d;
			phase_q      <= phase_d;
			pon_q        <= pon_d;
			chg_q        <= chg_d;
			rech_q       <= rech_d;
			prev_usb_q   <= prev_usb_d;
			prev_ac_q    <= prev_ac_d;
			pulse_cnt_q  <= pulse_cnt_d;
			switch_cnt_q <= switch_cnt_d;
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (load) begin
			res_s3 <= res_d;
		end
	end

endmodule
